### hdl/pp_pkg.sv
package pp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST,
		ST_EDGE,
		ST_XSTART,
		ST_CROSS,
		ST_EMITX,
		ST_EMITV,
		ST_NEXT,
		ST_MARK,
		ST_FIN
	} pp_state_t;

	localparam int CFG_INDEX_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_X     = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_Y     = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_Z     = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_OFFSET = 8'd3;

	localparam logic signed [15:0] NORMAL_Z_RESET = 16'sd16384;

endpackage

### hdl/polygon_plane_clipper.sv
// Clips a closed polygon against one plane (Sutherland-Hodgman, one plane).
// Vertices come in one per transfer on s_axis, tlast marking the closing vertex;
// clipped vertices leave on m_axis, tlast on the last one of the polygon, and a
// polygon clipped away entirely gives one end marker with tuser low and zero data.
// Each vertex's distance N.v - offset is formed bit-serially. Each crossing point
// runs three divisions, one per axis, on one shared serial divider; the closing
// vertex can need two crossings, and an output stall holds the block.
// The block takes one vertex at a time; the user must write configuration only
// while idle, and the block itself does not enforce it.
module polygon_plane_clipper import pp_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pos_x, pos_y, pos_z
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_x, out_y, out_z
	output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	// vertex_valid
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int CB  = COORD_BITS;
	localparam int TDW = ((3*CB+7)/8)*8;
	localparam int DW  = ((CB + 16 > 32) ? CB + 16 : 32) + 2;
	localparam int XW  = DW + 1;
	localparam int AW  = CB + 1;

	pp_state_t state_q, state_d;

	logic signed [15:0]    nx_q, ny_q, nz_q;
	logic signed [31:0]    off_q;

	logic signed [CB-1:0]  cur_q [3];
	logic signed [CB-1:0]  prev_q [3];
	logic signed [CB-1:0]  first_q [3];
	logic signed [CB-1:0]  xs_q [3];
	logic signed [DW-1:0]  cur_d_q, prev_d_q, first_d_q;
	logic                  closing_q;
	logic                  have_q;
	logic                  edge2_q;
	logic                  emitted_q;
	logic [1:0]            ax_q;

	logic                  m_valid_q;
	logic [3*CB-1:0]       m_data_q;
	logic                  m_user_q, m_last_q;

	logic                  in_acc;
	logic                  dist_done, div_done;
	logic signed [DW-1:0]  dist_val;
	logic [AW-1:0]         div_q;

	logic signed [CB-1:0]  v0 [3];
	logic signed [CB-1:0]  v1 [3];
	logic signed [DW-1:0]  d0, d1;
	logic                  in0, in1;
	logic signed [CB:0]    delta;
	logic [AW-1:0]         a_mag;
	logic [XW-1:0]         b_mag, c_mag;
	logic signed [DW:0]    den;
	logic signed [CB+1:0]  xres;

	logic                  can_emit;
	logic                  emit;
	logic [3*CB-1:0]       emit_data;
	logic                  emit_user, emit_last;
	logic                  div_start;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign can_emit  = !m_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			v0[k] = edge2_q ? cur_q[k] : prev_q[k];
			v1[k] = edge2_q ? first_q[k] : cur_q[k];
		end
		d0  = edge2_q ? cur_d_q : prev_d_q;
		d1  = edge2_q ? first_d_q : cur_d_q;
		in0 = !d0[DW-1];
		in1 = !d1[DW-1];
		delta = (CB+1)'(v1[ax_q]) - (CB+1)'(v0[ax_q]);
		a_mag = delta[CB] ? AW'(-delta) : AW'(delta);
		b_mag = d0[DW-1] ? XW'(-(DW+1)'(d0)) : XW'(d0);
		den   = (DW+1)'(d0) - (DW+1)'(d1);
		c_mag = den[DW] ? XW'(-den) : XW'(den);
		xres  = delta[CB] ? (CB+2)'(v0[ax_q]) - (CB+2)'({1'b0, div_q})
		                  : (CB+2)'(v0[ax_q]) + (CB+2)'({1'b0, div_q});
	end

	pp_dist #(.CB(CB), .DW(DW)) u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_acc),
		.pos_x        (s_axis_tdata[CB-1:0]),
		.pos_y        (s_axis_tdata[2*CB-1:CB]),
		.pos_z        (s_axis_tdata[3*CB-1:2*CB]),
		.normal_x     (nx_q),
		.normal_y     (ny_q),
		.normal_z     (nz_q),
		.plane_offset (off_q),
		.done         (dist_done),
		.dist_val     (dist_val)
	);

	pp_xdiv #(.AW(AW), .XW(XW)) u_xdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (a_mag),
		.b      (b_mag),
		.c      (c_mag),
		.done   (div_done),
		.q      (div_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_DIST;
			ST_DIST: begin
				if (dist_done) begin
					if (have_q || closing_q) state_d = ST_EDGE;
					else                     state_d = ST_FIN;
				end
			end
			ST_EDGE: begin
				if (in0 != in1) state_d = ST_XSTART;
				else if (in1)   state_d = ST_EMITV;
				else            state_d = ST_NEXT;
			end
			ST_XSTART: state_d = ST_CROSS;
			ST_CROSS: begin
				if (div_done) state_d = (ax_q == 2'd2) ? ST_EMITX : ST_XSTART;
			end
			ST_EMITX:  if (can_emit) state_d = in1 ? ST_EMITV : ST_NEXT;
			ST_EMITV:  if (can_emit) state_d = ST_NEXT;
			ST_NEXT: begin
				if (!edge2_q && closing_q)   state_d = ST_EDGE;
				else if (edge2_q && !emitted_q) state_d = ST_MARK;
				else                         state_d = ST_FIN;
			end
			ST_MARK:   if (can_emit) state_d = ST_FIN;
			ST_FIN:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		emit          = 1'b0;
		emit_data     = '0;
		emit_user     = 1'b1;
		emit_last     = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_XSTART: div_start = 1'b1;
			ST_EMITX: begin
				emit      = can_emit;
				emit_data = {xs_q[2], xs_q[1], xs_q[0]};
				// exit point is last when the closing edge stays outside or is this edge
				emit_last = closing_q && !in1 && first_d_q[DW-1];
			end
			ST_EMITV: begin
				emit      = can_emit;
				emit_data = {v1[2], v1[1], v1[0]};
				emit_last = edge2_q;
			end
			ST_MARK: begin
				emit      = can_emit;
				emit_user = 1'b0;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			nx_q      <= '0;
			ny_q      <= '0;
			nz_q      <= NORMAL_Z_RESET;
			off_q     <= '0;
			have_q    <= 1'b0;
			edge2_q   <= 1'b0;
			emitted_q <= 1'b0;
			ax_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_NORMAL_X:     nx_q  <= cfg_data[15:0];
					CFG_NORMAL_Y:     ny_q  <= cfg_data[15:0];
					CFG_NORMAL_Z:     nz_q  <= cfg_data[15:0];
					CFG_PLANE_OFFSET: off_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_DIST && dist_done) begin
				have_q  <= 1'b1;
				edge2_q <= !have_q;
			end
			if (state_q == ST_EDGE) ax_q <= '0;
			if (state_q == ST_CROSS && div_done && ax_q != 2'd2) ax_q <= ax_q + 1'b1;
			if (state_q == ST_NEXT && !edge2_q && closing_q) edge2_q <= 1'b1;
			if (emit) emitted_q <= 1'b1;
			if (state_q == ST_FIN) begin
				emitted_q <= 1'b0;
				edge2_q   <= 1'b0;
				if (closing_q) have_q <= 1'b0;
			end
			if (emit)               m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q[0]  <= s_axis_tdata[CB-1:0];
			cur_q[1]  <= s_axis_tdata[2*CB-1:CB];
			cur_q[2]  <= s_axis_tdata[3*CB-1:2*CB];
			closing_q <= s_axis_tlast;
		end
		if (state_q == ST_DIST && dist_done) begin
			cur_d_q <= dist_val;
			if (!have_q) begin
				first_q   <= cur_q;
				first_d_q <= dist_val;
			end
		end
		if (state_q == ST_CROSS && div_done) xs_q[ax_q] <= xres[CB-1:0];
		if (state_q == ST_FIN) begin
			prev_q   <= cur_q;
			prev_d_q <= cur_d_q;
		end
		if (emit) begin
			m_data_q <= emit_data;
			m_user_q <= emit_user;
			m_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = TDW'(m_data_q);
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule

### hdl/pp_dist.sv
module pp_dist import pp_pkg::*; #(
	parameter int CB = 16,
	parameter int DW = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [CB-1:0] pos_x,
	input  logic signed [CB-1:0] pos_y,
	input  logic signed [CB-1:0] pos_z,
	input  logic signed [15:0]   normal_x,
	input  logic signed [15:0]   normal_y,
	input  logic signed [15:0]   normal_z,
	input  logic signed [31:0]   plane_offset,
	output logic                 done,
	output logic signed [DW-1:0] dist_val
);

	localparam int CNTW = $clog2(CB + 1);

	logic [CB-1:0]         x_q, y_q, z_q;
	logic signed [DW-1:0]  acc_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic signed [DW-1:0]  dist_q;
	logic signed [17:0]    sum;
	logic signed [17:0]    addend;

	// one coordinate bit per cycle, msb first, sign bit carries negative weight
	always_comb begin
		sum = (x_q[CB-1] ? 18'(normal_x) : 18'sd0)
			+ (y_q[CB-1] ? 18'(normal_y) : 18'sd0)
			+ (z_q[CB-1] ? 18'(normal_z) : 18'sd0);
		addend = (cnt_q == '0) ? -sum : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(CB)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= pos_x;
			y_q   <= pos_y;
			z_q   <= pos_z;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNTW'(CB)) begin
				dist_q <= acc_q - DW'(plane_offset);
			end else begin
				acc_q <= (acc_q <<< 1) + {{(DW-18){addend[17]}}, addend};
				x_q   <= x_q << 1;
				y_q   <= y_q << 1;
				z_q   <= z_q << 1;
			end
		end
	end

	assign done     = done_q;
	assign dist_val = dist_q;

endmodule

### hdl/pp_xdiv.sv
module pp_xdiv import pp_pkg::*; #(
	parameter int AW = 17,
	parameter int XW = 35
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [XW-1:0] b,
	input  logic [XW-1:0] c,
	output logic          done,
	output logic [AW-1:0] q
);

	// floor(a * b / c) with b <= c, one bit of a per cycle, quotient digit 0..2
	localparam int CNTW = $clog2(AW);

	logic [AW-1:0]   a_q;
	logic [XW-1:0]   b_q, c_q, r_q;
	logic [AW-1:0]   q_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [XW+1:0]   t, t1, t2;
	logic [XW-1:0]   r_nxt;
	logic [1:0]      digit;

	always_comb begin
		t  = {r_q, 1'b0} + (a_q[AW-1] ? (XW+2)'(b_q) : '0);
		t1 = t - (XW+2)'(c_q);
		t2 = t - (XW+2)'({c_q, 1'b0});
		if (!t2[XW+1]) begin
			r_nxt = t2[XW-1:0];
			digit = 2'd2;
		end else if (!t1[XW+1]) begin
			r_nxt = t1[XW-1:0];
			digit = 2'd1;
		end else begin
			r_nxt = t[XW-1:0];
			digit = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(AW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			c_q <= c;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			r_q <= r_nxt;
			q_q <= {q_q[AW-2:0], 1'b0} + AW'(digit);
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

### hdl/pp_chk.sv
module pp_chk import pp_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_axis_tvalid,
	input logic                                  s_axis_tready,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [((3*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata,
	input logic                                  m_axis_tuser,
	input logic                                  m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled output changed");

	// one vertex at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	// end marker closes the polygon and carries no coordinates
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("bad end marker");

endmodule

bind polygon_plane_clipper pp_chk #(.COORD_BITS(COORD_BITS)) u_pp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
